[sv/srec_pkg.sv]
// ----------------------------------------------------------------------------
// S-record decoder package
// Shared constants, codes, types and character helpers of the line decoder.
// ----------------------------------------------------------------------------
package srec_pkg;

  localparam int unsigned MAX_DATA_BYTES_DEF = 32;

  localparam logic [7:0] CH_START = 8'h53;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_ENTRY   = 2'd2,
    KIND_ACCEPT  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PARSE,
    ST_CHECK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Number of address digits for each record type.
  function automatic logic [3:0] addr_digits(input logic [3:0] t);
    logic [3:0] r;
    case (t)
      4'd2, 4'd6, 4'd8: r = 4'd6;
      4'd3, 4'd4, 4'd7: r = 4'd8;
      default:          r = 4'd4;
    endcase
    return r;
  endfunction

endpackage

[sv/srec_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module srec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/srec_alu.sv]
// ----------------------------------------------------------------------------
// Shared adder
// The adder that checksum accumulation and byte addresses share.
// ----------------------------------------------------------------------------
module srec_alu (
  input  srec_pkg::alu_req_t req_i,
  output logic [31:0]        sum_o
);

  assign sum_o = req_i.a + req_i.b;

endmodule

[sv/srecord_line_decoder_core.sv]
// ----------------------------------------------------------------------------
// S-record line decoder
// Parses S-record text one character per beat and emits byte writes, entry
// addresses, accepts or an invalid mark when a carriage return ends the line.
// ----------------------------------------------------------------------------
// A character is accepted in the idle state, then parsed in the parse state
// through the shared adder. A line feed is accepted without leaving idle.
// A carriage return passes the check state, then gives one result per cycle
// while the sink is ready; data results read the byte buffer one entry per cycle.
// Reset clears the sequencer and all line state; the byte buffer is not cleared.
// ----------------------------------------------------------------------------
module srecord_line_decoder_core #(
  parameter int unsigned MAX_DATA_BYTES = srec_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // ch[7:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // rec_type[3:0], address[35:4], data_byte[43:36]
  output logic [1:0]  m_axis_tuser_o,   // kind[1:0]
  output logic        m_axis_tlast_o
);

  localparam int unsigned POS_SAT = (2 * MAX_DATA_BYTES + 15 > 127) ?
                                    (2 * MAX_DATA_BYTES + 15) : 127;
  localparam int unsigned PW = $clog2(POS_SAT + 1);
  localparam int unsigned NW = $clog2(MAX_DATA_BYTES + 1);
  localparam int unsigned AW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  srec_pkg::state_e state_q, state_d;

  logic [7:0]    ch_q;
  logic [PW-1:0] pos_q, pos_d;
  logic [3:0]    type_q, type_d;
  logic [31:0]   addr_q, addr_d;
  logic [3:0]    nib_q, nib_d;
  logic [NW-1:0] bytes_q, bytes_d;
  logic [NW-1:0] n_q, n_d;
  logic [PW-1:0] addr_end_q, addr_end_d;
  logic [PW-1:0] end_q, end_d;
  logic [7:0]    sum_q, sum_d;
  logic [7:0]    chk_q, chk_d;
  logic          bad_q, bad_d;
  srec_pkg::kind_e res_kind_q, res_kind_d;
  logic [NW-1:0] idx_q, idx_d;

  logic                  out_valid_q;
  srec_pkg::kind_e       out_kind_q;
  logic [3:0]            out_type_q;
  logic [31:0]           out_addr_q;
  logic [7:0]            out_data_q;
  logic                  out_last_q;

  srec_pkg::alu_req_t alu_req;
  logic [31:0]        alu_y;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [7:0]         ram_rdata;
  logic [7:0]         cur_byte;

  logic       in_acc, out_free, load_out, res_last;
  logic [4:0] hex;
  logic [NW:0] idx_inc;
  logic [8:0] cnt_ext;
  logic [8:0] cnt_n;
  logic [3:0] alen;
  logic [2:0] abytes;
  logic       ok;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign hex      = srec_pkg::hex_decode(ch_q);
  assign cur_byte = {nib_q, hex[3:0]};
  assign idx_inc  = {1'b0, idx_q} + 1'b1;
  assign alen     = srec_pkg::addr_digits(type_q);
  assign abytes   = alen[3:1];
  assign cnt_ext  = {1'b0, cur_byte};
  assign cnt_n    = cnt_ext - 9'({abytes, 1'b0} >> 1) - 9'd1;
  assign res_last = (res_kind_q != srec_pkg::KIND_DATA) || (idx_inc == {1'b0, n_q});

  assign ok = !bad_q && (pos_q >= PW'(4)) && (pos_q >= end_q) &&
              (chk_q == ~sum_q) && (n_q == bytes_q);

  srec_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_y)
  );

  srec_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DATA_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bytes_q[AW-1:0]),
    .wdata_i (cur_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      srec_pkg::ST_IDLE: begin
        if (in_acc && s_axis_tdata_i == srec_pkg::CH_CR) begin
          state_d = srec_pkg::ST_CHECK;
        end else if (in_acc && s_axis_tdata_i != srec_pkg::CH_LF) begin
          state_d = srec_pkg::ST_PARSE;
        end
      end
      srec_pkg::ST_PARSE: state_d = srec_pkg::ST_IDLE;
      srec_pkg::ST_CHECK: state_d = srec_pkg::ST_EMIT;
      srec_pkg::ST_EMIT: begin
        if (out_free && res_last) begin
          state_d = srec_pkg::ST_IDLE;
        end
      end
      default: state_d = srec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    alu_req.a       = {24'd0, sum_q};
    alu_req.b       = {24'd0, cur_byte};
    ram_re          = 1'b0;
    ram_raddr       = '0;
    load_out        = 1'b0;
    case (state_q)
      srec_pkg::ST_IDLE:  s_axis_tready_o = 1'b1;
      srec_pkg::ST_CHECK: ram_re = 1'b1;
      srec_pkg::ST_EMIT: begin
        alu_req.a = addr_q;
        alu_req.b = 32'(idx_q);
        load_out  = out_free;
        ram_re    = out_free;
        ram_raddr = idx_inc[AW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    pos_d      = pos_q;
    type_d     = type_q;
    addr_d     = addr_q;
    nib_d      = nib_q;
    bytes_d    = bytes_q;
    n_d        = n_q;
    addr_end_d = addr_end_q;
    end_d      = end_q;
    sum_d      = sum_q;
    chk_d      = chk_q;
    bad_d      = bad_q;
    res_kind_d = res_kind_q;
    idx_d      = idx_q;
    ram_we     = 1'b0;
    case (state_q)
      srec_pkg::ST_PARSE: begin
        if (pos_q < PW'(POS_SAT)) begin
          pos_d = pos_q + 1'b1;
        end
        if (!bad_q) begin
          if (pos_q == '0) begin
            bad_d = (ch_q != srec_pkg::CH_START);
          end else if (pos_q == PW'(1)) begin
            if (!hex[4] || hex[3:0] > 4'd9) begin
              bad_d = 1'b1;
            end else begin
              type_d     = hex[3:0];
              addr_end_d = PW'(4) + PW'(srec_pkg::addr_digits(hex[3:0]));
            end
          end else if (pos_q >= PW'(4) && pos_q >= end_q) begin
            bad_d = bad_q;
          end else if (!hex[4]) begin
            bad_d = 1'b1;
          end else if (!pos_q[0]) begin
            nib_d = hex[3:0];
          end else if (pos_q == PW'(3)) begin
            sum_d = alu_y[7:0];
            if (cnt_ext < 9'({1'b0, abytes}) + 9'd1 ||
                cnt_n > 9'(MAX_DATA_BYTES)) begin
              bad_d = 1'b1;
            end
            n_d   = cnt_n[NW-1:0];
            end_d = PW'(6) + PW'(alen) + PW'({cnt_n[NW-1:0], 1'b0});
          end else if (pos_q < addr_end_q) begin
            addr_d = {addr_q[23:0], cur_byte};
            sum_d  = alu_y[7:0];
          end else if (pos_q < end_q - PW'(2)) begin
            if (bytes_q < NW'(MAX_DATA_BYTES)) begin
              ram_we  = 1'b1;
              bytes_d = bytes_q + 1'b1;
            end
            sum_d = alu_y[7:0];
          end else begin
            chk_d = cur_byte;
          end
        end
      end
      srec_pkg::ST_CHECK: begin
        idx_d = '0;
        if (!ok) begin
          res_kind_d = srec_pkg::KIND_INVALID;
        end else if (type_q >= 4'd1 && type_q <= 4'd3 && n_q != '0) begin
          res_kind_d = srec_pkg::KIND_DATA;
        end else if (type_q >= 4'd7) begin
          res_kind_d = srec_pkg::KIND_ENTRY;
        end else begin
          res_kind_d = srec_pkg::KIND_ACCEPT;
        end
      end
      srec_pkg::ST_EMIT: begin
        if (out_free) begin
          idx_d = idx_inc[NW-1:0];
          if (res_last) begin
            pos_d      = '0;
            type_d     = '0;
            addr_d     = '0;
            nib_d      = '0;
            bytes_d    = '0;
            n_d        = '0;
            addr_end_d = '0;
            end_d      = '0;
            sum_d      = '0;
            chk_d      = '0;
            bad_d      = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srec_pkg::ST_IDLE;
      pos_q       <= '0;
      type_q      <= '0;
      addr_q      <= '0;
      nib_q       <= '0;
      bytes_q     <= '0;
      n_q         <= '0;
      addr_end_q  <= '0;
      end_q       <= '0;
      sum_q       <= '0;
      chk_q       <= '0;
      bad_q       <= 1'b0;
      res_kind_q  <= srec_pkg::KIND_INVALID;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      type_q     <= type_d;
      addr_q     <= addr_d;
      nib_q      <= nib_d;
      bytes_q    <= bytes_d;
      n_q        <= n_d;
      addr_end_q <= addr_end_d;
      end_q      <= end_d;
      sum_q      <= sum_d;
      chk_q      <= chk_d;
      bad_q      <= bad_d;
      res_kind_q <= res_kind_d;
      idx_q      <= idx_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q <= s_axis_tdata_i;
    end
    if (load_out) begin
      out_kind_q <= res_kind_q;
      out_last_q <= res_last;
      case (res_kind_q)
        srec_pkg::KIND_DATA: begin
          out_type_q <= type_q;
          out_addr_q <= alu_y;
          out_data_q <= ram_rdata;
        end
        srec_pkg::KIND_ENTRY, srec_pkg::KIND_ACCEPT: begin
          out_type_q <= type_q;
          out_addr_q <= addr_q;
          out_data_q <= '0;
        end
        default: begin
          out_type_q <= '0;
          out_addr_q <= '0;
          out_data_q <= '0;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_data_q, out_addr_q, out_type_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

[verif/srecord_line_decoder_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// S-record line decoder testbench
// Sends S-record text one character per beat. The text covers directed records
// and error cases, then a random mix of good, damaged and noise lines. A
// line-level predictor builds the expected result beats. Each result beat is
// checked against the oldest pending one. Both sides idle at random, and the
// result side holds off once for a long stretch so that the decoder stalls.
// ----------------------------------------------------------------------------
module srecord_line_decoder_core_tb;
  import srec_pkg::*;

  localparam int MAX_BYTES          = MAX_DATA_BYTES_DEF;
  localparam int POS_LIMIT          = (2 * MAX_BYTES + 15) > 127 ? (2 * MAX_BYTES + 15) : 127;
  localparam int ADDR_NIBBLES [10]  = '{4, 4, 6, 8, 8, 4, 6, 8, 6, 4};
  localparam int HOLD_CYCLES        = 600;
  localparam int CYCLE_LIMIT        = 400000;
  localparam int DRAIN_LIMIT        = 5000;
  localparam int RANDOM_CHARS       = 30;
  localparam int MAX_REPORTS        = 10;

  typedef logic [7:0] line_t[$];

  typedef struct {
    kind_e       kind;
    logic [3:0]  rec_type;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic        last;
  } srec_result_t;

  class srec_line_tracker;
    srec_result_t pending_results[$];
    int           predicted;
    int           mismatches;
    int           pos;
    int           stored;
    logic [3:0]   rtype;
    logic [3:0]   nib;
    logic [7:0]   count;
    logic [7:0]   sum;
    logic [7:0]   chk;
    logic [31:0]  raddr;
    logic [7:0]   buffer [MAX_BYTES];
    bit           bad;

    function new();
      clear_line();
      predicted  = 0;
      mismatches = 0;
    endfunction

    function void clear_line();
      pos    = 0;
      stored = 0;
      rtype  = '0;
      nib    = '0;
      count  = '0;
      sum    = '0;
      chk    = '0;
      raddr  = '0;
      bad    = 1'b0;
    endfunction

    function int data_count();
      return int'(count) - ADDR_NIBBLES[rtype] / 2 - 1;
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
    endfunction

    function void push_result(kind_e k, logic [3:0] t, logic [31:0] a, logic [7:0] d,
                              logic l);
      srec_result_t r;
      r.kind      = k;
      r.rec_type  = t;
      r.address   = a;
      r.data_byte = d;
      r.last      = l;
      pending_results.push_back(r);
      predicted++;
    endfunction

    function void take_char(logic [7:0] c);
      int         p;
      int         v;
      int         alen;
      int         n;
      int         rel;
      logic [7:0] b;
      p = pos;
      if (pos < POS_LIMIT) pos++;
      if (bad) return;
      if (p == 0) begin
        bad = (c != CH_START);
        return;
      end
      v = hex_value(c);
      if (p == 1) begin
        if (v < 0 || v > 9) bad = 1'b1;
        else rtype = v[3:0];
        return;
      end
      alen = ADDR_NIBBLES[rtype];
      rel  = p - 4;
      if (p >= 4 && rel >= alen + 2 * data_count() + 2) return;
      if (v < 0) begin
        bad = 1'b1;
        return;
      end
      if (p % 2 == 0) begin
        nib = v[3:0];
        return;
      end
      b = {nib, v[3:0]};
      if (p == 3) begin
        count = b;
        sum   = sum + b;
        if (int'(count) < alen / 2 + 1 || data_count() > MAX_BYTES) bad = 1'b1;
        return;
      end
      n = data_count();
      if (rel < alen) begin
        raddr = {raddr[23:0], b};
        sum   = sum + b;
      end else if (rel < alen + 2 * n) begin
        if (stored < MAX_BYTES) begin
          buffer[stored] = b;
          stored++;
        end
        sum = sum + b;
      end else begin
        chk = b;
      end
    endfunction

    function void end_line();
      bit ok;
      int n;
      ok = !bad && pos >= 4;
      n  = 0;
      if (ok) begin
        n = data_count();
        if (pos < 4 + ADDR_NIBBLES[rtype] + 2 * n + 2) ok = 1'b0;
        else if (chk != ~sum) ok = 1'b0;
        else if (n != stored) ok = 1'b0;
      end
      if (!ok) begin
        push_result(KIND_INVALID, '0, '0, '0, 1'b1);
      end else if (rtype >= 1 && rtype <= 3 && n > 0) begin
        for (int i = 0; i < n; i++) begin
          push_result(KIND_DATA, rtype, raddr + i, buffer[i], i == n - 1);
        end
      end else if (rtype >= 7) begin
        push_result(KIND_ENTRY, rtype, raddr, '0, 1'b1);
      end else begin
        push_result(KIND_ACCEPT, rtype, raddr, '0, 1'b1);
      end
      clear_line();
    endfunction

    function void note_char(logic [7:0] c);
      if (c == CH_LF) return;
      if (c == CH_CR) end_line();
      else take_char(c);
    endfunction

    function void check_beat(logic [1:0] kind, logic [3:0] rt, logic [31:0] a,
                             logic [7:0] d, logic l);
      srec_result_t w;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: unexpected result beat kind=%0d type=%0d addr=%h byte=%h last=%b",
                   kind, rt, a, d, l);
        end
        return;
      end
      w = pending_results.pop_front();
      if (kind !== w.kind || rt !== w.rec_type || a !== w.address ||
          d !== w.data_byte || l !== w.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: expected kind=%0d type=%0d addr=%h byte=%h last=%b",
                   w.kind, w.rec_type, w.address, w.data_byte, w.last);
          $display("       got      kind=%0d type=%0d addr=%h byte=%h last=%b",
                   kind, rt, a, d, l);
        end
      end
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic        rx_hold       = 1'b0;
  bit          hold_req      = 1'b0;
  bit          tx_burst      = 1'b0;
  int          chars_sent    = 0;
  int          cycle_count   = 0;

  srec_line_tracker tracker;

  srecord_line_decoder_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] hex_char(logic [3:0] v, bit mixed);
    if (v < 4'd10) return 8'h30 + 8'(v);
    if (mixed && $urandom_range(0, 1) == 1) return 8'h61 + 8'(v) - 8'd10;
    return 8'h41 + 8'(v) - 8'd10;
  endfunction

  function automatic void push_byte(ref line_t q, input logic [7:0] b, input bit mixed);
    q.push_back(hex_char(b[7:4], mixed));
    q.push_back(hex_char(b[3:0], mixed));
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_CR) ? 8'h8D : b;
  endfunction

  function automatic line_t make_record(int rt, logic [31:0] a, int n, int count_adj,
                                        bit bad_sum, bit mixed);
    line_t      q;
    int         alen;
    logic [7:0] cnt;
    logic [7:0] sum;
    logic [7:0] b;
    alen = ADDR_NIBBLES[rt];
    cnt  = 8'(alen / 2 + n + 1 + count_adj);
    q.push_back(CH_START);
    q.push_back(8'h30 + 8'(rt));
    push_byte(q, cnt, mixed);
    sum = cnt;
    for (int i = alen / 2 - 1; i >= 0; i--) begin
      b = a[8 * i +: 8];
      push_byte(q, b, mixed);
      sum = sum + b;
    end
    repeat (n) begin
      b = 8'($urandom);
      push_byte(q, b, mixed);
      sum = sum + b;
    end
    b = ~sum;
    if (bad_sum) b = b ^ (8'd1 << $urandom_range(0, 7));
    push_byte(q, b, mixed);
    return q;
  endfunction

  function automatic line_t random_line();
    line_t       q;
    int          rt;
    int          n;
    int          cut;
    logic [31:0] a;
    rt = $urandom_range(0, 9);
    a  = $urandom;
    n  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_BYTES) : $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      6: q = make_record(rt, a, n, int'($urandom_range(0, 4)) - 2, $urandom_range(0, 1),
                         $urandom_range(0, 1));
      7: begin
        q = make_record(rt, a, n, 0, 1'b0, 1'b1);
        q[$urandom_range(0, q.size() - 1)] = noise_char();
      end
      8: begin
        q   = make_record(rt, a, n, 0, 1'b0, 1'b1);
        cut = $urandom_range(0, q.size() - 1);
        while (q.size() > cut) void'(q.pop_back());
      end
      9: repeat ($urandom_range(0, 20)) q.push_back(noise_char());
      default: begin
        q = make_record(rt, a, n, 0, 1'b0, $urandom_range(0, 1));
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 5)) q.push_back(noise_char());
        end
      end
    endcase
    if ($urandom_range(0, 7) == 0) q.insert($urandom_range(0, q.size()), CH_LF);
    return q;
  endfunction

  task automatic send_char(logic [7:0] c);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    tracker.note_char(c);
    if (c != CH_LF) chars_sent++;
  endtask

  task automatic send_line(line_t q);
    tx_burst = ($urandom_range(0, 3) == 0);
    foreach (q[i]) send_char(q[i]);
    send_char(CH_CR);
  endtask

  initial begin
    int rx_wait;
    bit rx_burst;
    rx_wait  = 0;
    rx_burst = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (m_axis_tready && m_axis_tvalid === 1'b1) begin
        tracker.check_beat(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[35:4],
                           m_axis_tdata[43:36], m_axis_tlast);
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_axis_tready <= (rx_wait == 0) && !rx_hold;
    end
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timeout after %0d cycles", cycle_count);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    line_t q;
    int    base_chars;
    int    drain;
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    hold_req = 1'b1;

    // The longest record, with trailing text that runs past the position limit.
    q = make_record(3, $urandom, MAX_BYTES, 0, 1'b0, 1'b0);
    repeat (POS_LIMIT - q.size() + 3) q.push_back(8'h20 + 8'($urandom_range(0, 94)));
    send_line(q);
    send_line(make_record(3, 32'hFFFF_FFFE, 4, 0, 1'b0, 1'b1));
    q = make_record(1, $urandom, 1, 0, 1'b0, 1'b0);
    q[0] = "s";
    send_line(q);
    q = make_record(1, $urandom, 1, 0, 1'b0, 1'b0);
    q[1] = "A";
    send_line(q);
    send_line(make_record(1, $urandom, 0, -1, 1'b0, 1'b0));
    send_line(make_record(1, $urandom, 0, MAX_BYTES + 1, 1'b0, 1'b0));
    q = make_record(2, $urandom, 1, 0, 1'b0, 1'b0);
    q[10] = " ";
    send_line(q);
    q = make_record(1, $urandom, 1, 0, 1'b0, 1'b0);
    void'(q.pop_back());
    void'(q.pop_back());
    send_line(q);
    q.delete();
    send_line(q);
    q.push_back(CH_START);
    q.push_back("1");
    q.push_back("0");
    send_line(q);
    q = make_record(9, $urandom, 0, 0, 1'b0, 1'b0);
    q.push_back("X");
    q.push_back(8'hFF);
    q.push_back(" ");
    send_line(q);
    send_line(make_record(2, $urandom, 1, 0, 1'b1, 1'b0));
    q = make_record(1, $urandom, 1, 0, 1'b0, 1'b0);
    q.insert(5, CH_LF);
    send_line(q);

    base_chars = chars_sent;
    while (chars_sent < base_chars + RANDOM_CHARS) begin
      send_line(random_line());
    end
    s_axis_tvalid <= 1'b0;

    drain = 0;
    while (tracker.pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (tracker.pending_results.size() != 0) begin
      $display("ERROR: %0d expected result beats never arrived",
               tracker.pending_results.size());
      tracker.mismatches += tracker.pending_results.size();
    end
    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
